// ===== hw/rtl/twr_pkg.sv =====
// shared types and constants for the three-wire register access master
// used by twr_engine, the top level and the port checker
package twr_pkg;

  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 20;
  localparam int NUM_MODULES = 4;
  localparam int SEND_BITS   = ADDR_BITS + 1 + DATA_BITS;
  localparam int CNT_W       = 5;
  localparam int DELAY_W     = 16;
  localparam int MOD_W       = 2;
  localparam int TDATA_W     = 32;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

  localparam logic [CNT_W-1:0] FRAME_READ_BITS  = CNT_W'(ADDR_BITS + 1);
  localparam logic [CNT_W-1:0] FRAME_WRITE_BITS = CNT_W'(SEND_BITS);
  localparam logic [CNT_W-1:0] READ_BITS        = CNT_W'(DATA_BITS);

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SEND_LOW  = 3'd1,
    PH_SEND_HIGH = 3'd2,
    PH_READ_WAIT = 3'd3,
    PH_READ_HIGH = 3'd4,
    PH_READ_LOW  = 3'd5
  } phase_t;

  // input item, first field in the highest bits
  typedef struct packed {
    logic                 data_in;
    logic [DATA_BITS-1:0] write_data;
    logic [ADDR_BITS-1:0] reg_addr;
    logic [MOD_W-1:0]     module_req;
    logic [1:0]           cmd;
  } in_item_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic                   read_done;
    logic [DATA_BITS-1:0]   read_data;
    logic                   busy_res;
    logic                   data_drive_enable;
    logic                   serial_data_out;
    logic                   serial_clock;
    logic [NUM_MODULES-1:0] chip_select_n;
  } result_t;

  localparam int ITEM_W   = $bits(in_item_t);
  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hw/rtl/twr_engine.sv =====
// bit engine: transaction state, delay register and one-tick step logic
// depends on twr_pkg
module twr_engine
  import twr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  in_item_t           item,
  input  logic               cfg_we,
  input  logic [DELAY_W-1:0] cfg_delay,
  output result_t            res
);

  logic [DELAY_W-1:0]   delay_ticks;
  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     bit_count, bit_count_next;
  logic [DELAY_W-1:0]   tick_timer, tick_timer_next;
  logic [SEND_BITS-1:0] send_shift, send_shift_next;
  logic [DATA_BITS-1:0] read_shift, read_shift_next;
  logic [MOD_W-1:0]     active_module, active_module_next;
  logic                 is_write, is_write_next;

  logic [DELAY_W-1:0]   unit;
  logic [DELAY_W:0]     tick_sum;
  logic                 unit_end;
  logic [CNT_W-1:0]     bit_inc;
  logic [CNT_W-1:0]     frame_bits;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks   <= DELAY_RESET;
      phase         <= PH_IDLE;
      bit_count     <= '0;
      tick_timer    <= '0;
      send_shift    <= '0;
      read_shift    <= '0;
      active_module <= '0;
      is_write      <= 1'b0;
    end else begin
      if (cfg_we) begin
        delay_ticks <= cfg_delay;
      end
      if (step) begin
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        tick_timer    <= tick_timer_next;
        send_shift    <= send_shift_next;
        read_shift    <= read_shift_next;
        active_module <= active_module_next;
        is_write      <= is_write_next;
      end
    end
  end

  // unit timing, a zero delay acts as one
  assign unit       = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
  assign tick_sum   = {1'b0, tick_timer} + (DELAY_W+1)'(1);
  assign unit_end   = tick_sum >= {1'b0, unit};
  assign bit_inc    = bit_count + CNT_W'(1);
  assign frame_bits = is_write ? FRAME_WRITE_BITS : FRAME_READ_BITS;

  // next state for one tick
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    tick_timer_next    = tick_timer;
    send_shift_next    = send_shift;
    read_shift_next    = read_shift;
    active_module_next = active_module;
    is_write_next      = is_write;
    res.read_done      = 1'b0;
    res.read_data      = '0;

    if (phase == PH_IDLE) begin
      if (item.cmd == CMD_READ || item.cmd == CMD_WRITE) begin
        is_write_next      = (item.cmd == CMD_WRITE);
        active_module_next = item.module_req;
        send_shift_next    = {item.write_data, (item.cmd == CMD_WRITE), item.reg_addr};
        read_shift_next    = '0;
        bit_count_next     = '0;
        tick_timer_next    = '0;
        phase_next         = PH_SEND_LOW;
      end
    end else if (!unit_end) begin
      tick_timer_next = tick_sum[DELAY_W-1:0];
    end else begin
      tick_timer_next = '0;
      case (phase)
        PH_SEND_LOW: begin
          phase_next = PH_SEND_HIGH;
        end
        PH_SEND_HIGH: begin
          send_shift_next = send_shift >> 1;
          if (bit_inc >= frame_bits) begin
            bit_count_next = '0;
            phase_next     = is_write ? PH_IDLE : PH_READ_WAIT;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_SEND_LOW;
          end
        end
        PH_READ_WAIT: begin
          // bits arrive lsb first, so shift in from the top
          read_shift_next = {item.data_in, read_shift[DATA_BITS-1:1]};
          phase_next      = PH_READ_HIGH;
        end
        PH_READ_HIGH: begin
          phase_next = PH_READ_LOW;
        end
        PH_READ_LOW: begin
          if (bit_inc >= READ_BITS) begin
            bit_count_next = '0;
            res.read_data  = read_shift;
            res.read_done  = 1'b1;
            phase_next     = PH_IDLE;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_READ_WAIT;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // pin levels after the tick
    res.chip_select_n = '1;
    if (phase_next != PH_IDLE) begin
      res.chip_select_n[active_module_next] = 1'b0;
    end
    res.serial_clock = (phase_next == PH_SEND_HIGH) || (phase_next == PH_READ_HIGH);
    res.serial_data_out = ((phase_next == PH_SEND_LOW) || (phase_next == PH_SEND_HIGH))
                          ? send_shift_next[0] : 1'b0;
    res.data_drive_enable = (phase_next == PH_IDLE) || (phase_next == PH_SEND_LOW) ||
                            (phase_next == PH_SEND_HIGH);
    res.busy_res = (phase_next != PH_IDLE);
  end

endmodule

// ===== hw/rtl/three_wire_register_access_master.sv =====
// Three-wire register access master, LSB first, for four modules.
//
// Each transaction on the s_axis channel is one timebase tick carrying a
// command (tick only, start read, start write), the module, the register
// address, the write data and the sampled level of the data line. Every
// tick gives exactly one transaction on the m_axis channel with the pin
// levels after that tick: chip selects, serial clock, data out, data
// drive enable, busy, and the read word with its done flag.
// The cfg channel writes delay_ticks (ticks per bus phase); it is
// always ready. The user must write it only while no transaction is in
// flight; the block itself does not enforce this. A tick is taken into
// the input register, stepped into the result register once that is
// free, and then shows on m_axis. Throughput: one tick per cycle while
// m_axis does not stall; the step logic runs once per accepted tick
// between the two registers. When m_axis stalls the result register
// holds and the input register still takes one more tick;
// s_axis_tready then drops until the result is taken. Reset clears
// both valid flags, the bus state goes idle and delay_ticks returns to 100.
// depends on twr_pkg and twr_engine
module three_wire_register_access_master
  import twr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // cmd[1:0], module_req[3:2], reg_addr[7:4], write_data[27:8], data_in[28]
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  // chip_select_n[3:0], serial_clock[4], serial_data_out[5],
  // data_drive_enable[6], busy_res[7], read_data[27:8], read_done[28]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DELAY_W-1:0] cfg_data
);

  logic     in_valid;
  in_item_t in_item;
  logic     out_valid;
  result_t  out_res;
  result_t  step_res;
  logic     advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= in_item_t'(s_axis_tdata[ITEM_W-1:0]);
    end
  end

  // one tick of the bus engine
  twr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_delay (cfg_data),
    .res       (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(TDATA_W-RESULT_W)'(0), out_res};

endmodule

// ===== hw/rtl/twr_port_checker.sv =====
// port-level checks for the three-wire register access master
// depends on twr_pkg; bound to three_wire_register_access_master
module twr_port_checker
  import twr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // with no result pending the input side is open
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // read done only when the bus has returned to idle
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[28] |-> !m_axis_tdata[7] && m_axis_tdata[3:0] == 4'hF)
    else $error("read done while bus active");

  // idle bus: selects high, line driven low, clock low
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[7] |->
      m_axis_tdata[3:0] == 4'hF && m_axis_tdata[6] && !m_axis_tdata[5] && !m_axis_tdata[4])
    else $error("idle bus levels wrong");

endmodule

bind three_wire_register_access_master twr_port_checker u_port_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/twr_pin_checker.sv =====
// scoreboard for the three-wire register access master: predicts the pin
// levels that follow every accepted tick and compares them with m_axis
// depends on twr_pkg for the item, result and phase types
module twr_pin_checker
  import twr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TDATA_W-1:0] m_axis_tdata,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [DELAY_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked,
  output int                 frames_started
);

  // predicted bus state
  phase_t                 bus_ph;
  logic [CNT_W-1:0]       bit_cnt;
  logic [DELAY_W-1:0]     unit_ticks;
  logic [SEND_BITS-1:0]   send_sr;
  logic [DATA_BITS-1:0]   read_sr;
  logic [MOD_W-1:0]       sel_module;
  logic                   frame_write;
  logic [DELAY_W-1:0]     delay_q;

  // pin levels still owed by the block, oldest first
  result_t expected_pins[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic clear_bus();
    bus_ph      = PH_IDLE;
    bit_cnt     = '0;
    unit_ticks  = '0;
    send_sr     = '0;
    read_sr     = '0;
    sel_module  = '0;
    frame_write = 1'b0;
    delay_q     = DELAY_RESET;
  endtask

  // one timebase tick of the serial engine, returns the pins after it
  task automatic step_bus(input in_item_t it, output result_t r);
    int unit;
    int t;
    int frame;
    logic [DATA_BITS-1:0] rword;
    logic done;
    unit  = (delay_q == '0) ? 1 : int'(delay_q);
    rword = '0;
    done  = 1'b0;
    if (bus_ph == PH_IDLE) begin
      // starts only from idle, command 3 falls through as a plain tick
      if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
        frame_write = (it.cmd == CMD_WRITE);
        sel_module  = it.module_req;
        send_sr     = {it.write_data, frame_write, it.reg_addr};
        read_sr     = '0;
        bit_cnt     = '0;
        unit_ticks  = '0;
        bus_ph      = PH_SEND_LOW;
        frames_started++;
      end
    end else begin
      // a unit ends once its elapsed ticks reach the current delay
      t = int'(unit_ticks) + 1;
      if (t < unit) begin
        unit_ticks = DELAY_W'(t);
      end else begin
        unit_ticks = '0;
        case (bus_ph)
          PH_SEND_LOW: bus_ph = PH_SEND_HIGH;
          PH_SEND_HIGH: begin
            send_sr = send_sr >> 1;
            bit_cnt++;
            frame = frame_write ? SEND_BITS : ADDR_BITS + 1;
            if (int'(bit_cnt) >= frame) begin
              bit_cnt = '0;
              bus_ph  = frame_write ? PH_IDLE : PH_READ_WAIT;
            end else begin
              bus_ph = PH_SEND_LOW;
            end
          end
          PH_READ_WAIT: begin
            read_sr[bit_cnt] = it.data_in;
            bus_ph = PH_READ_HIGH;
          end
          PH_READ_HIGH: bus_ph = PH_READ_LOW;
          default: begin
            bit_cnt++;
            if (bit_cnt >= READ_BITS) begin
              bit_cnt = '0;
              rword   = read_sr;
              done    = 1'b1;
              bus_ph  = PH_IDLE;
            end else begin
              bus_ph = PH_READ_WAIT;
            end
          end
        endcase
      end
    end

    // pin levels after the tick
    r.chip_select_n = '1;
    if (bus_ph != PH_IDLE)
      r.chip_select_n[sel_module] = 1'b0;
    r.serial_clock      = (bus_ph == PH_SEND_HIGH || bus_ph == PH_READ_HIGH);
    r.serial_data_out   = (bus_ph == PH_SEND_LOW || bus_ph == PH_SEND_HIGH) ? send_sr[0] : 1'b0;
    r.data_drive_enable = !(bus_ph == PH_READ_WAIT || bus_ph == PH_READ_HIGH ||
                            bus_ph == PH_READ_LOW);
    r.busy_res          = (bus_ph != PH_IDLE);
    r.read_data         = rword;
    r.read_done         = done;
  endtask

  // watch the three channels at every rising edge
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      clear_bus();
      expected_pins.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        delay_q = cfg_data;

      // results first, so a result never matches the tick taken this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RESULT_W-1:0]);
        if (expected_pins.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, '0);
        end else begin
          want = expected_pins.pop_front();
          results_checked++;
          if (got.chip_select_n !== want.chip_select_n)
            report_mismatch("chip_select_n", 32'(got.chip_select_n),
                            32'(want.chip_select_n));
          if (got.serial_clock !== want.serial_clock)
            report_mismatch("serial_clock", 32'(got.serial_clock), 32'(want.serial_clock));
          if (got.serial_data_out !== want.serial_data_out)
            report_mismatch("serial_data_out", 32'(got.serial_data_out),
                            32'(want.serial_data_out));
          if (got.data_drive_enable !== want.data_drive_enable)
            report_mismatch("data_drive_enable", 32'(got.data_drive_enable),
                            32'(want.data_drive_enable));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
          if (got.read_done !== want.read_done)
            report_mismatch("read_done", 32'(got.read_done), 32'(want.read_done));
          if (m_axis_tdata[TDATA_W-1:RESULT_W] !== '0)
            report_mismatch("tdata padding", m_axis_tdata, '0);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        step_bus(in_item_t'(s_axis_tdata[ITEM_W-1:0]), want);
        expected_pins.push_back(want);
      end
    end
    pending = expected_pins.size();
  end

endmodule

// ===== tb/three_wire_register_access_master_test.sv =====
// testbench top for the three-wire register access master: drives ticks,
// delay writes and back-pressure; twr_pin_checker does the checking
// depends on twr_pkg, twr_pin_checker and the block under test
module three_wire_register_access_master_test;
  import twr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum {DIN_LOW, DIN_HIGH, DIN_TOGGLE, DIN_RANDOM} din_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DELAY_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int results_checked;
  int frames_started;
  int cycle_count = 0;
  int delay_writes = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  // 12 unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  three_wire_register_access_master u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  twr_pin_checker u_check (.*);

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAIL three_wire_register_access_master");
      $finish;
    end
  end

  // receiver: stall pattern switches between no, 30 percent and 75 percent stalls
  initial begin : receiver
    int mode_left;
    int stall_pct;
    int held;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // long hold-off so the block backs up into s_axis
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      mode_left--;
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic in_item_t make_item(input logic [1:0] c, input logic [MOD_W-1:0] m,
                                         input logic [ADDR_BITS-1:0] a,
                                         input logic [DATA_BITS-1:0] w, input logic d);
    in_item_t it;
    it.cmd        = c;
    it.module_req = m;
    it.reg_addr   = a;
    it.write_data = w;
    it.data_in    = d;
    return it;
  endfunction

  // mostly ticks, with starts that land both on idle and busy cycles
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 66)
      it.cmd = CMD_TICK;
    else if (r < 72)
      it.cmd = CMD_UNUSED;
    else if (r < 86)
      it.cmd = CMD_READ;
    else
      it.cmd = CMD_WRITE;
    it.module_req = MOD_W'($urandom);
    it.reg_addr   = ADDR_BITS'($urandom);
    case ($urandom_range(0, 7))
      0: it.write_data = '0;
      1: it.write_data = '1;
      default: it.write_data = DATA_BITS'($urandom);
    endcase
    it.data_in = 1'($urandom);
    return it;
  endfunction

  // offer one tick and hold it until taken
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(it);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom;
  endtask

  // stop offering and wait until every owed result has come out
  task automatic drain_results();
    idle_cycle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= DELAY_W'($urandom);
    delay_writes++;
  endtask

  // tick-only items with a chosen level on the data line
  task automatic tick_run(input int n, input din_mode_t mode);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = random_item();
      it.cmd = CMD_TICK;
      case (mode)
        DIN_LOW:    it.data_in = 1'b0;
        DIN_HIGH:   it.data_in = 1'b1;
        DIN_TOGGLE: it.data_in = i[0];
        default:    it.data_in = 1'($urandom);
      endcase
      send_item(it);
    end
  endtask

  // random ticks in bursts, optional gaps, optional drain part way through
  task automatic run_phase(input int n, input bit gaps, input int drain_at);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (i == drain_at)
        drain_results();
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if (gaps)
          repeat ($urandom_range(0, 6)) idle_cycle();
      end
      send_item(random_item());
      burst--;
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [DELAY_W-1:0] phase_delay [6];
    phase_delay = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd1, DELAY_W'($urandom_range(1, 4))};
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // idle ticks at the reset delay, the unused command acts as a tick
    send_item(make_item(CMD_TICK, 2'd0, 4'h0, 20'h00000, 1'b0));
    send_item(make_item(CMD_UNUSED, 2'd3, 4'hF, 20'hFFFFF, 1'b1));

    // largest delay, bus stays idle
    write_delay(16'hFFFF);
    tick_run(3, DIN_RANDOM);

    // zero delay behaves as one tick per unit
    write_delay(16'h0000);
    send_item(make_item(CMD_WRITE, 2'd3, 4'hF, 20'hFFFFF, 1'b1));
    send_item(make_item(CMD_READ, 2'd0, 4'h0, 20'h00000, 1'b0));  // ignored while busy
    tick_run(55, DIN_RANDOM);
    send_item(make_item(CMD_READ, 2'd0, 4'h0, 20'h00000, 1'b1));
    tick_run(75, DIN_HIGH);
    send_item(make_item(CMD_WRITE, 2'd1, 4'h0, 20'h00000, 1'b0));
    send_item(make_item(CMD_UNUSED, 2'd2, 4'h6, 20'h12345, 1'b0));
    tick_run(55, DIN_LOW);
    send_item(make_item(CMD_READ, 2'd2, 4'h5, 20'h5A5A5, 1'b0));
    tick_run(75, DIN_TOGGLE);

    // delay changed while a frame is running, shorter then longer
    write_delay(16'd3);
    send_item(make_item(CMD_WRITE, 2'd2, 4'h9, 20'hA5A5A, 1'b0));
    tick_run(11, DIN_RANDOM);
    write_delay(16'd1);
    tick_run(20, DIN_RANDOM);
    write_delay(16'd4);
    tick_run(230, DIN_RANDOM);

    // random phases over several delay settings
    for (int p = 0; p < 6; p++) begin
      write_delay(phase_delay[p]);
      if (p == 1)
        hold_req <= 1'b1;
      run_phase(180, p != 0, (p == 2) ? 90 : -1);
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("checked %0d results over %0d frames and %0d delay settings",
             results_checked, frames_started, delay_writes);
    $display("receiver hold-off %s, mismatches %0d", hold_done ? "done" : "missed", fail_count);
    if (fail_count == 0 && pending == 0)
      $display("PASS three_wire_register_access_master");
    else
      $display("FAIL three_wire_register_access_master");
    $finish;
  end

endmodule
